// File: design/clsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clsr_pkg;

   typedef logic [30:0] word_type;
   typedef logic [15:0] mult_type;
   typedef logic [7:0]  corr_type;

   localparam word_type MOD1       = 31'd2147483563;
   localparam word_type MOD2       = 31'd2147483399;
   localparam mult_type MUL1       = 16'd40014;
   localparam mult_type MUL2       = 16'd40692;
   // 2^31 minus each modulus, used to fold the high part of a product
   localparam corr_type CORR1      = 8'd85;
   localparam corr_type CORR2      = 8'd249;
   localparam word_type OUT_SPAN   = 31'd2147483562;
   localparam word_type GEN2_RESET = 31'd123456789;
   localparam word_type GEN1_RESET = 31'd1;

   typedef struct packed {
      logic load_seed;
      logic mul;
      logic warm_fold;
      logic step_fold;
      logic read;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic warm_last;
   } status_type;

endpackage

`default_nettype wire

// File: design/clsr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clsr_req_if;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   clsr_pkg::word_type   seed_magnitude;

   modport source (output valid, output mode, output seed_magnitude, input ready);
   modport sink   (input valid, input mode, input seed_magnitude, output ready);
endinterface

`default_nettype wire

// File: design/clsr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clsr_rsp_if;
   logic                 valid;
   logic                 ready;
   clsr_pkg::word_type   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: design/clsr_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none

// Multiply modulo 2^31 - c: product registered, then folded.
module clsr_mulmod (
   input  logic               clock,
   input  logic               load,
   input  logic               second,
   input  clsr_pkg::word_type operand,
   output clsr_pkg::word_type result
);
   import clsr_pkg::*;

   logic [46:0] prod_ff;
   logic [46:0] prod_in;
   mult_type    mult;
   corr_type    corr;
   word_type    modulus;
   logic [15:0] hi;
   logic [30:0] lo;
   logic [23:0] hi_corr;
   logic [31:0] sum;

   assign mult    = second ? MUL2 : MUL1;
   assign corr    = second ? CORR2 : CORR1;
   assign modulus = second ? MOD2 : MOD1;

   assign prod_in = 47'(operand) * 47'(mult);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // hi*2^31 == hi*c (mod 2^31 - c); the sum stays below twice the modulus
   assign hi      = prod_ff[46:31];
   assign lo      = prod_ff[30:0];
   assign hi_corr = 24'(hi) * 24'(corr);
   assign sum     = 32'(lo) + 32'(hi_corr);

   always_comb begin
      if (sum >= 32'(modulus)) begin
         result = 31'(sum - 32'(modulus));
      end else begin
         result = sum[30:0];
      end
   end

endmodule

`default_nettype wire

// File: design/clsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module clsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  clsr_pkg::status_type status,
   output clsr_pkg::cmd_type    cmd
);
   import clsr_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SEED_MUL  = 3'd1;
   localparam logic [2:0] ST_SEED_FOLD = 3'd2;
   localparam logic [2:0] ST_MUL       = 3'd3;
   localparam logic [2:0] ST_FOLD      = 3'd4;
   localparam logic [2:0] ST_READ      = 3'd5;
   localparam logic [2:0] ST_FINISH    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_seed = req_mode;
               state_in      = req_mode ? ST_SEED_MUL : ST_MUL;
            end
         end
         ST_SEED_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SEED_FOLD;
         end
         ST_SEED_FOLD: begin
            cmd.warm_fold = 1'b1;
            state_in      = status.warm_last ? ST_MUL : ST_SEED_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.step_fold = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold here while the previous word is still unclaimed
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/clsr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module clsr_dpath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  clsr_pkg::word_type   seed_magnitude,
   input  clsr_pkg::cmd_type    cmd,
   output clsr_pkg::status_type status,
   output clsr_pkg::word_type   value
);
   import clsr_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 8);
   localparam longint unsigned SLOT_DIV = 64'd1 + 64'(OUT_SPAN) / TABLE_DEPTH;
   // slot = last / SLOT_DIV via reciprocal; estimate is exact or one low
   localparam int SLOT_SHIFT = 37;
   localparam longint unsigned RECIP = (64'd1 << SLOT_SHIFT) / SLOT_DIV;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int QPROD_W = 31 + RECIP_W;
   localparam int Q_W = QPROD_W - SLOT_SHIFT;
   localparam int BND_W = Q_W + 1 + 31;

   word_type               gen1_ff, gen1_in;
   word_type               gen2_ff, gen2_in;
   word_type               last_ff, last_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff;
   logic [QPROD_W-1:0]     qprod_ff;
   logic [IW-1:0]          slot_ff, slot_in;
   word_type               rd_ff;
   logic                   rd_valid_ff;
   word_type               value_ff;
   word_type               mem [TABLE_DEPTH];

   word_type               fold1, fold2;
   word_type               seed;
   word_type               picked;
   word_type               result;
   logic [Q_W-1:0]         q_est;
   logic [BND_W-1:0]       bound;
   logic [Q_W:0]           q_fix;
   logic                   mem_we;
   logic [IW-1:0]          mem_waddr;
   word_type               mem_wdata;

   clsr_mulmod u_mm1 (
      .clock   (clock),
      .load    (cmd.mul),
      .second  (1'b0),
      .operand (gen1_ff),
      .result  (fold1)
   );

   clsr_mulmod u_mm2 (
      .clock   (clock),
      .load    (cmd.mul),
      .second  (1'b1),
      .operand (gen2_ff),
      .result  (fold2)
   );

   assign seed = (seed_magnitude == '0) ? 31'd1 : seed_magnitude;

   // slot correction from the registered reciprocal product
   assign q_est = qprod_ff[QPROD_W-1:SLOT_SHIFT];
   assign bound = BND_W'(q_est + 1'b1) * BND_W'(SLOT_DIV);
   assign q_fix = (Q_W + 1)'(q_est) + (Q_W + 1)'(BND_W'(last_ff) >= bound);

   always_comb begin
      if (int'(q_fix) >= TABLE_DEPTH) begin
         slot_in = IW'(TABLE_DEPTH - 1);
      end else begin
         slot_in = IW'(q_fix);
      end
   end

   assign picked = rd_valid_ff ? rd_ff : '0;

   always_comb begin
      if (picked > gen2_ff) begin
         result = picked - gen2_ff;
      end else begin
         result = OUT_SPAN - (gen2_ff - picked);
      end
   end

   assign mem_we    = (cmd.warm_fold && (count_ff < CW'(TABLE_DEPTH))) || cmd.finish;
   assign mem_waddr = cmd.finish ? slot_ff : count_ff[IW-1:0];
   assign mem_wdata = cmd.finish ? gen1_ff : fold1;

   always_comb begin
      gen1_in  = gen1_ff;
      gen2_in  = gen2_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      if (cmd.load_seed) begin
         gen1_in = seed;
         gen2_in = seed;
      end
      if (cmd.warm_fold) begin
         gen1_in = fold1;
         if (count_ff == '0) begin
            last_in = fold1;
         end
      end
      if (cmd.step_fold) begin
         gen1_in = fold1;
         gen2_in = fold2;
      end
      if (cmd.finish) begin
         last_in = result;
      end
      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen1_ff  <= GEN1_RESET;
         gen2_ff  <= GEN2_RESET;
         last_ff  <= '0;
         valid_ff <= '0;
      end else begin
         gen1_ff  <= gen1_in;
         gen2_ff  <= gen2_in;
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_seed) begin
         count_ff <= CW'(TABLE_DEPTH + 7);
      end else if (cmd.warm_fold && (count_ff != '0)) begin
         count_ff <= count_ff - 1'b1;
      end
      if (cmd.mul) begin
         qprod_ff <= QPROD_W'(last_ff) * QPROD_W'(RECIP);
      end
      if (cmd.step_fold) begin
         slot_ff <= slot_in;
      end
      if (cmd.finish) begin
         value_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         rd_ff       <= mem[slot_ff];
         rd_valid_ff <= valid_ff[slot_ff];
      end
   end

   assign status.warm_last = (count_ff == '0);
   assign value            = value_ff;

endmodule

`default_nettype wire

// File: design/combined_lcg_shuffle_rng_top.sv
// Sequence: after a next-number word is accepted the controller walks multiply, fold,
// table read and table update, then shows the word on rsp; a reseed word first adds
// TABLE_DEPTH + 8 warm-up steps, each a multiply and a fold of the multiply-fold unit.
// A new req is taken only in idle, not mid-word; it is taken while a result waits on rsp.
// Reset: generators go to 1 and 123456789, last output to 0, table entries read as zero
// until written (per-entry valid bits cleared at once).
`timescale 1ns / 1ps
`default_nettype none

module combined_lcg_shuffle_rng_top #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   clsr_req_if.sink   req_ch,
   clsr_rsp_if.source rsp_ch
);
   import clsr_pkg::*;

   cmd_type    cmd;
   status_type status;

   clsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   clsr_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .seed_magnitude (req_ch.seed_magnitude),
      .cmd            (cmd),
      .status         (status),
      .value          (rsp_ch.value)
   );

endmodule

`default_nettype wire

// File: verif/combined_lcg_shuffle_rng_top_tb.sv
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_top_tb;
   import clsr_pkg::*;

   localparam int TABLE_DEPTH = 32;
   localparam int unsigned SLOT_DIV = 1 + 32'(OUT_SPAN) / TABLE_DEPTH;
   localparam logic MODE_NEXT   = 1'b0;
   localparam logic MODE_RESEED = 1'b1;
   localparam int RANDOM_WORDS = 1180;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_LEN     = 200;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam word_type SEED_MAX = 31'h7FFFFFFF;

   typedef struct packed {
      logic     mode;
      word_type seed;
   } number_req_type;

   logic clock;
   logic reset;

   clsr_req_if req_ch();
   clsr_rsp_if rsp_ch();

   combined_lcg_shuffle_rng_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // generator model state
   word_type gen_a;
   word_type gen_b;
   word_type prev_out;
   word_type shuffle [TABLE_DEPTH];

   number_req_type pending_reqs[$];
   word_type       expected_values[$];

   number_req_type cur_req;
   logic        offering;
   int          tx_wait;
   logic        tx_calm;
   int          rx_wait;
   int          rx_hold;
   logic        rx_calm;
   logic        req_taken;
   logic        rsp_taken;
   int          results_seen;
   int          idle_cycles;
   int          error_count;
   word_type    want;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic word_type mul_mod(word_type x, mult_type a, word_type m);
      logic [63:0] prod;
      prod = 64'(x) * 64'(a);
      return word_type'(prod % 64'(m));
   endfunction

   function automatic void reseed_generators(word_type magnitude);
      word_type s;
      s = (magnitude == '0) ? word_type'(1) : magnitude;
      gen_a = s;
      gen_b = s;
      // 8 discarded steps, then the table fills from the top entry down
      for (int k = TABLE_DEPTH + 7; k >= 0; k--) begin
         gen_a = mul_mod(gen_a, MUL1, MOD1);
         if (k < TABLE_DEPTH) shuffle[k] = gen_a;
      end
      prev_out = shuffle[0];
   endfunction

   function automatic word_type next_number();
      int unsigned slot;
      word_type    picked;
      word_type    result;
      gen_a = mul_mod(gen_a, MUL1, MOD1);
      gen_b = mul_mod(gen_b, MUL2, MOD2);
      slot = 32'(prev_out) / SLOT_DIV;
      if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
      picked = shuffle[slot];
      if (picked > gen_b) begin
         result = picked - gen_b;
      end else begin
         result = OUT_SPAN - (gen_b - picked);
      end
      shuffle[slot] = gen_a;
      prev_out = result;
      return result;
   endfunction

   function automatic void add_req(logic mode, word_type seed);
      number_req_type r;
      r.mode = mode;
      r.seed = seed;
      pending_reqs.push_back(r);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (offering && req_taken) begin
            offering = 1'b0;
            tx_wait = tx_calm ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0) tx_calm = ~tx_calm;
         end else if (!offering && tx_wait > 0) begin
            tx_wait--;
         end
         if (!offering && tx_wait == 0 && pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            offering = 1'b1;
         end
         req_ch.valid <= offering;
         req_ch.mode <= cur_req.mode;
         req_ch.seed_magnitude <= cur_req.seed;
      end
   end

   // receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0) rx_calm = ~rx_calm;
            if (results_seen == HOLD_AT) rx_hold = HOLD_LEN;
         end else begin
            if (rx_wait > 0) rx_wait--;
            if (rx_hold > 0) rx_hold--;
         end
         rsp_ch.ready <= (rx_wait == 0 && rx_hold == 0);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.mode == MODE_RESEED) reseed_generators(req_ch.seed_magnitude);
            expected_values.push_back(next_number());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_values.size() == 0) begin
               error_count++;
               $display("%0t: value with none expected: actual %0d", $time, rsp_ch.value);
            end else begin
               want = expected_values.pop_front();
               if (rsp_ch.value !== want) begin
                  error_count++;
                  $display("%0t: value mismatch: expected %0d actual %0d",
                           $time, want, rsp_ch.value);
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      word_type seed;
      logic     mode;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_NEXT;
      req_ch.seed_magnitude = '0;
      rsp_ch.ready = 1'b0;
      cur_req = '0;
      offering = 1'b0;
      tx_wait = 0;
      tx_calm = 1'b0;
      rx_wait = 0;
      rx_hold = 0;
      rx_calm = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      results_seen = 0;
      idle_cycles = 0;
      error_count = 0;

      gen_a = GEN1_RESET;
      gen_b = GEN2_RESET;
      prev_out = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) shuffle[i] = '0;

      // steps from the reset state, before any seed
      add_req(MODE_NEXT, '0);
      add_req(MODE_NEXT, SEED_MAX);
      add_req(MODE_NEXT, '0);
      // zero seed acts as one
      add_req(MODE_RESEED, '0);
      add_req(MODE_NEXT, '0);
      add_req(MODE_RESEED, 31'd1);
      add_req(MODE_NEXT, '0);
      add_req(MODE_RESEED, SEED_MAX);
      add_req(MODE_NEXT, '0);
      // seed equal to a modulus pins that generator at zero
      add_req(MODE_RESEED, MOD1);
      add_req(MODE_NEXT, '0);
      add_req(MODE_NEXT, '0);
      add_req(MODE_RESEED, MOD2);
      add_req(MODE_NEXT, '0);
      add_req(MODE_NEXT, '0);
      add_req(MODE_RESEED, MOD1 - 31'd1);
      add_req(MODE_NEXT, '0);
      add_req(MODE_RESEED, MOD2 + 31'd1);
      add_req(MODE_NEXT, '0);
      add_req(MODE_RESEED, 31'h2AAAAAAA);
      add_req(MODE_RESEED, 31'h55555555);
      add_req(MODE_NEXT, SEED_MAX);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         mode = ($urandom_range(0, 15) == 0) ? MODE_RESEED : MODE_NEXT;
         seed = word_type'($urandom());
         if (mode == MODE_RESEED && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: seed = '0;
               1: seed = MOD1;
               2: seed = MOD2;
               default: seed = SEED_MAX;
            endcase
         end
         add_req(mode, seed);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_reqs.size() > 0 || offering || expected_values.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
